FILE: sv/full_linear_convolution_top_macros.svh
// Assertion macros used by the convolution controller.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef FULL_LINEAR_CONVOLUTION_TOP_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is low
`define FLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define FLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define FLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FLC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/flc_pkg.sv
// Shared types and constants for the full linear convolution block.
// No dependencies; compiled first.
package flc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int CONV_W   = 37;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SIGNAL = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP_OUT,
        S_MAC,
        S_DRAIN,
        S_SIG_OUT,
        S_TAIL_SHIFT
    } t_state;

    typedef struct packed {
        logic tap_start;
        logic tap_append;
        logic hist_shift;
        logic hist_zero;
        logic hist_clear;
        logic mac_issue;
        logic acc_clear;
        logic emit;
        logic emit_zero;
        logic emit_last;
        logic emit_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic tap_full;
        logic out_free;
        logic pipe_busy;
    } t_dp_stat;

endpackage

FILE: sv/flc_in_if.sv
// Input channel: valid/ready handshake with one tap or signal request.
// Depends on flc_pkg.
interface flc_in_if;
    import flc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_signal;

    modport source (output valid, output operation, output sample_value,
                    output end_of_signal, input ready);
    modport sink   (input valid, input operation, input sample_value,
                    input end_of_signal, output ready);
endinterface

FILE: sv/flc_out_if.sv
// Output channel: valid/ready handshake with one convolution result.
// Depends on flc_pkg.
interface flc_out_if;
    import flc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CONV_W-1:0] conv_value;
    logic                     last_of_run;
    logic                     tap_overflow;

    modport source (output valid, output conv_value, output last_of_run,
                    output tap_overflow, input ready);
    modport sink   (input valid, input conv_value, input last_of_run,
                    input tap_overflow, output ready);
endinterface

FILE: sv/full_linear_convolution_top.sv
// Tap request: S_TAP_OUT registers a zero result once the output register is free; no new
// request is taken until then. Signal request with N taps: a MAC pass through the one shared
// multiplier (RAM read, product, accumulate) precedes each registered result; the last sample
// adds N-1 tail passes. The next request is taken the cycle after the last result is
// registered; a stalled output register holds the sequencer.
// Synchronous active-low reset clears tap count, history valid bits and control, not tap RAM.
module full_linear_convolution_top #(
    parameter int MAX_TAPS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    flc_in_if.sink    i_in,
    flc_out_if.source o_out
);
    import flc_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] mac_k;
    logic [CW-1:0] tap_count;
    logic          ready;

    assign i_in.ready = ready;

    flc_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_operation (i_in.operation),
        .i_eos       (i_in.end_of_signal),
        .o_ready     (ready),
        .i_stat      (stat),
        .i_tap_count (tap_count),
        .o_cmd       (cmd),
        .o_mac_k     (mac_k)
    );

    flc_dpath #(.MAX_TAPS(MAX_TAPS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mac_k     (mac_k),
        .i_sample    (i_in.sample_value),
        .o_stat      (stat),
        .o_tap_count (tap_count),
        .o_out       (o_out)
    );
endmodule

FILE: sv/flc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: sv/flc_dpath.sv
// Datapath: tap and history RAMs, history valid bits, shared MAC pipeline,
// output register. Depends on flc_pkg, flc_ram, flc_out_if.
module flc_dpath #(
    parameter int MAX_TAPS = 32,
    localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int CW      = $clog2(MAX_TAPS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  flc_pkg::t_dp_cmd                    i_cmd,
    input  logic [AW-1:0]                       i_mac_k,
    input  logic signed [flc_pkg::SAMPLE_W-1:0] i_sample,
    output flc_pkg::t_dp_stat                   o_stat,
    output logic [CW-1:0]                       o_tap_count,
    flc_out_if.source                           o_out
);
    import flc_pkg::*;

    logic [CW-1:0]       r_tap_count;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       n_wp;
    logic [MAX_TAPS-1:0] r_hvalid;

    logic [AW-1:0]       tap_wr_addr;
    logic [AW:0]         hdiff;
    logic [AW-1:0]       haddr;
    logic [SAMPLE_W-1:0] hist_wr_data;
    logic [SAMPLE_W-1:0] tap_rd;
    logic [SAMPLE_W-1:0] hist_rd;
    logic signed [SAMPLE_W-1:0] tap_q;
    logic signed [SAMPLE_W-1:0] hist_m;

    logic                     r_p1;
    logic                     r_p2;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [CONV_W-1:0] r_acc;

    logic                     r_out_valid;
    logic signed [CONV_W-1:0] r_conv;
    logic                     r_last;
    logic                     r_ovf;

    assign tap_wr_addr  = i_cmd.tap_start ? '0 : r_tap_count[AW-1:0];
    assign n_wp         = (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + AW'(1);
    assign hist_wr_data = i_cmd.hist_zero ? '0 : i_sample;

    // newest sample sits at r_wp; tap k pairs with the entry k places back
    assign hdiff = {1'b0, r_wp} - {1'b0, i_mac_k};
    assign haddr = hdiff[AW] ? AW'(hdiff + (AW+1)'(MAX_TAPS)) : hdiff[AW-1:0];

    flc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.tap_start | i_cmd.tap_append),
        .i_wr_addr (tap_wr_addr),
        .i_wr_data (i_sample),
        .i_rd_addr (i_mac_k),
        .o_rd_data (tap_rd)
    );

    flc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.hist_shift),
        .i_wr_addr (n_wp),
        .i_wr_data (hist_wr_data),
        .i_rd_addr (haddr),
        .o_rd_data (hist_rd)
    );

    assign tap_q  = tap_rd;
    assign hist_m = r_v1 ? hist_rd : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_wp        <= '0;
            r_hvalid    <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tap_start) begin
                r_tap_count <= CW'(1);
            end else if (i_cmd.tap_append) begin
                r_tap_count <= r_tap_count + CW'(1);
            end
            if (i_cmd.hist_clear) begin
                r_hvalid <= '0;
            end else if (i_cmd.hist_shift) begin
                r_wp           <= n_wp;
                r_hvalid[n_wp] <= 1'b1;
            end
            r_p1 <= i_cmd.mac_issue;
            r_p2 <= r_p1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= r_hvalid[haddr];
        r_prod <= tap_q * hist_m;
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + {{(CONV_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.emit) begin
            r_conv <= i_cmd.emit_zero ? '0 : r_acc;
            r_last <= i_cmd.emit_last;
            r_ovf  <= i_cmd.emit_ovf;
        end
    end

    assign o_stat.tap_full  = (r_tap_count == CW'(MAX_TAPS));
    assign o_stat.out_free  = !r_out_valid || o_out.ready;
    assign o_stat.pipe_busy = r_p1 | r_p2;
    assign o_tap_count      = r_tap_count;

    assign o_out.valid        = r_out_valid;
    assign o_out.conv_value   = r_conv;
    assign o_out.last_of_run  = r_last;
    assign o_out.tap_overflow = r_ovf;
endmodule

FILE: sv/flc_ctrl.sv
// Controller: request decode, MAC pass sequencing, tail flush and result emit.
// Depends on flc_pkg and the assertion macro header.
`include "full_linear_convolution_top_macros.svh"

module flc_ctrl #(
    parameter int MAX_TAPS = 32,
    localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int CW      = $clog2(MAX_TAPS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [flc_pkg::OP_W-1:0]    i_operation,
    input  logic                        i_eos,
    output logic                        o_ready,
    input  flc_pkg::t_dp_stat           i_stat,
    input  logic [CW-1:0]               i_tap_count,
    output flc_pkg::t_dp_cmd            o_cmd,
    output logic [AW-1:0]               o_mac_k
);
    import flc_pkg::*;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_k;
    logic [CW-1:0] n_k;
    logic [CW-1:0] r_t;
    logic [CW-1:0] n_t;
    logic          r_eos;
    logic          n_eos;
    logic          r_ovf;
    logic          n_ovf;
    logic          accept;
    logic          sig_last;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    // r_t counts results of this request, the current one included
    assign sig_last = !r_eos || (r_t >= i_tap_count);
    assign o_mac_k  = r_k[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_START, OP_APPEND: n_state = S_TAP_OUT;
                        OP_SIGNAL:           n_state = S_MAC;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_TAP_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_MAC: begin
                if (r_k == i_tap_count) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_SIG_OUT;
            end
            S_SIG_OUT: begin
                if (i_stat.out_free) n_state = sig_last ? S_IDLE : S_TAIL_SHIFT;
            end
            S_TAIL_SHIFT: n_state = S_MAC;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_k   = r_k;
        n_t   = r_t;
        n_eos = r_eos;
        n_ovf = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_START: begin
                            o_cmd.tap_start = 1'b1;
                            n_ovf           = 1'b0;
                        end
                        OP_APPEND: begin
                            o_cmd.tap_append = !i_stat.tap_full;
                            n_ovf            = i_stat.tap_full;
                        end
                        OP_SIGNAL: begin
                            o_cmd.hist_shift = 1'b1;
                            o_cmd.acc_clear  = 1'b1;
                            n_k              = '0;
                            n_t              = CW'(1);
                            n_eos            = i_eos;
                        end
                        default: ;
                    endcase
                end
            end
            S_TAP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_zero = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_ovf  = r_ovf;
                end
            end
            S_MAC: begin
                if (r_k != i_tap_count) begin
                    o_cmd.mac_issue = 1'b1;
                    n_k             = r_k + CW'(1);
                end
            end
            S_DRAIN: ;
            S_SIG_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_last  = sig_last;
                    o_cmd.hist_clear = sig_last && r_eos;
                    if (!sig_last) n_t = r_t + CW'(1);
                end
            end
            S_TAIL_SHIFT: begin
                o_cmd.hist_shift = 1'b1;
                o_cmd.hist_zero  = 1'b1;
                o_cmd.acc_clear  = 1'b1;
                n_k              = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_t     <= '0;
            r_eos   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_t     <= n_t;
            r_eos   <= n_eos;
            r_ovf   <= n_ovf;
        end
    end

    `FLC_ASSERT_IMP(a_ready_pipe_empty, i_clk, i_rst_n, o_ready, !i_stat.pipe_busy)
    `FLC_ASSERT_IMP(a_issue_in_range, i_clk, i_rst_n, o_cmd.mac_issue, r_k < i_tap_count)
    `FLC_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free)
    `FLC_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.emit_last, r_state == S_IDLE)
endmodule
